// ===== rtl/world_to_screen_projection_unit_macros.svh =====
// Assertion helpers for the projection unit.
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTSP_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wtsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WTSP_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wtsp: next-cycle check failed");

`endif

// ===== rtl/wtsp_pkg.sv =====
`default_nettype none

package wtsp_pkg;

	localparam int ENTRY_W         = 32;
	localparam int MAT_N           = 16;
	localparam int MAT_IDX_W       = 4;
	localparam int WORLD_W         = 32;
	localparam int PROD_W          = 64;
	localparam int N_ROWS          = 4;
	localparam int N_AXES          = 3;
	localparam int FIX_SHIFT       = 8;
	localparam int DOT_W           = 58;
	localparam int NUMIN_W         = DOT_W + 1;
	localparam int SCALE_W         = 14;
	localparam int SCALE_SHIFT     = 15;
	localparam int NEAR_W          = 17;
	localparam int NEAR_SHIFT      = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 17;
	localparam int COORD_WIDTH_DEF = 32;

	localparam logic [SCALE_W-1:0] WIDTH_RST  = SCALE_W'(1920);
	localparam logic [SCALE_W-1:0] HEIGHT_RST = SCALE_W'(1080);
	localparam logic [NEAR_W-1:0]  NEAR_RST   = NEAR_W'(66);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_NEAR_LIMIT    = 2'd2
	} cfg_reg_t;

	localparam logic ACT_WRITE   = 1'b0;
	localparam logic ACT_PROJECT = 1'b1;

	typedef struct packed {
		logic v;
		logic rej;
		logic wz;
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/world_to_screen_projection_unit.sv =====
// Perspective projection of world points to screen pixels.
// Input channel (in_valid/in_ready): a request with action 0 stores entry_value
// (signed Q8.24) at entry_index of the 4x4 view matrix and gives no result; a
// request with action 1 projects world_x/y/z (signed Q16.16).
// Output channel (out_valid/out_ready): one result per projection, with the
// visible flag, screen_x/screen_y in signed Q17.15 pixels and the overflow flag.
// Configuration: cfg_write with cfg_index 0, 1, 2 sets screen width, screen
// height and near limit; write it only while the unit is empty.
// Throughput is one request per cycle while the receiver does not stall. A
// projection passes, in order, through matrix products, row sums, depth
// test and numerators, scaling and setup, a restoring divider with a stage
// for each quotient bit, and saturation and the output register.
// Reset clears the matrix to zero, loads 1920, 1080 and 66 into the
// configuration registers and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; nothing is lost or repeated.
`default_nettype none

`include "world_to_screen_projection_unit_macros.svh"

module world_to_screen_projection_unit import wtsp_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [MAT_IDX_W-1:0]          entry_index,
	input  logic signed [ENTRY_W-1:0]     entry_value,
	input  logic signed [WORLD_W-1:0]     world_x,
	input  logic signed [WORLD_W-1:0]     world_y,
	input  logic signed [WORLD_W-1:0]     world_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          visible,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic                          overflow
);

	localparam int DIV_LAT = COORD_WIDTH + 4;

	logic                         en;
	logic                         mat_wr;
	logic                         width_wr;
	logic [MAT_N-1:0][ENTRY_W-1:0] mat_q;
	logic [SCALE_W-1:0]           width_q;
	logic [SCALE_W-1:0]           height_q;
	logic [NEAR_W-1:0]            near_q;

	logic                         v_s1;
	logic                         v_s2;
	logic signed [DOT_W-1:0]      dot_s2 [N_ROWS];
	flags_t                       fl_s3;
	logic signed [NUMIN_W-1:0]    numx_s3;
	logic signed [NUMIN_W-1:0]    numy_s3;
	logic signed [DOT_W-1:0]      den_s3;
	flags_t                       fl_line [DIV_LAT];

	logic [COORD_WIDTH-1:0]       vx;
	logic [COORD_WIDTH-1:0]       vy;
	logic                         satx;
	logic                         saty;
	flags_t                       fl_end;
	logic                         vis_c;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign mat_wr   = in_valid && in_ready && action == ACT_WRITE;
	assign width_wr = cfg_write && cfg_index == CFG_SCREEN_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			near_q   <= NEAR_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data[SCALE_W-1:0];
				CFG_SCREEN_HEIGHT: height_q <= cfg_data[SCALE_W-1:0];
				CFG_NEAR_LIMIT:    near_q   <= cfg_data[NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (mat_wr) begin
			mat_q[entry_index] <= entry_value;
		end
	end

	wtsp_dot u_dot (
		.clk    (clk),
		.en     (en),
		.mat    (mat_q),
		.x      (world_x),
		.y      (world_y),
		.z      (world_z),
		.dot_s2 (dot_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			fl_s3  <= '0;
		end else if (en) begin
			v_s1      <= in_valid && action == ACT_PROJECT;
			v_s2      <= v_s1;
			fl_s3.v   <= v_s2;
			fl_s3.rej <= dot_s2[2] < $signed(DOT_W'({near_q, {NEAR_SHIFT{1'b0}}}));
			fl_s3.wz  <= dot_s2[3] == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3 <= {dot_s2[0][DOT_W-1], dot_s2[0]} + {dot_s2[3][DOT_W-1], dot_s2[3]};
			numy_s3 <= {dot_s2[3][DOT_W-1], dot_s2[3]} - {dot_s2[1][DOT_W-1], dot_s2[1]};
			den_s3  <= dot_s2[3];
		end
	end

	wtsp_div #(.CW(COORD_WIDTH)) u_div_x (
		.clk   (clk),
		.en    (en),
		.num   (numx_s3),
		.den   (den_s3),
		.scale (width_q),
		.value (vx),
		.sat   (satx)
	);

	wtsp_div #(.CW(COORD_WIDTH)) u_div_y (
		.clk   (clk),
		.en    (en),
		.num   (numy_s3),
		.den   (den_s3),
		.scale (height_q),
		.value (vy),
		.sat   (saty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				fl_line[i] <= '0;
			end
		end else if (en) begin
			fl_line[0] <= fl_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				fl_line[i] <= fl_line[i-1];
			end
		end
	end

	assign fl_end = fl_line[DIV_LAT-1];
	assign vis_c  = !fl_end.rej && !fl_end.wz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= fl_end.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible  <= vis_c;
			screen_x <= vis_c ? vx : '0;
			screen_y <= vis_c ? vy : '0;
			overflow <= fl_end.rej ? 1'b0 : (fl_end.wz ? 1'b1 : (satx | saty));
		end
	end

	`WTSP_ASSERT_NOW(a_hidden_zero, out_valid && !visible, screen_x == '0 && screen_y == '0)
	`WTSP_ASSERT_NEXT(a_mat_write, mat_wr, mat_q[$past(entry_index)] == $past(entry_value))
	`WTSP_ASSERT_NEXT(a_cfg_width, width_wr, width_q == $past(cfg_data[SCALE_W-1:0]))

endmodule

`default_nettype wire

// ===== rtl/wtsp_dot.sv =====
`default_nettype none

module wtsp_dot import wtsp_pkg::*; (
	input  logic                             clk,
	input  logic                             en,
	input  logic [MAT_N-1:0][ENTRY_W-1:0]    mat,
	input  logic signed [WORLD_W-1:0]        x,
	input  logic signed [WORLD_W-1:0]        y,
	input  logic signed [WORLD_W-1:0]        z,
	output logic signed [DOT_W-1:0]          dot_s2 [N_ROWS]
);

	logic signed [WORLD_W-1:0] crd [N_AXES];
	logic signed [PROD_W-1:0]  prod_s1 [N_ROWS*N_AXES];
	logic signed [ENTRY_W-1:0] bias_s1 [N_ROWS];
	logic signed [PROD_W-1:0]  acc [N_ROWS];

	assign crd[0] = x;
	assign crd[1] = y;
	assign crd[2] = z;

	// Products are taken straight from the request so that a matrix write
	// accepted later never reaches an item already in flight.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < N_ROWS; r++) begin
				for (int c = 0; c < N_AXES; c++) begin
					prod_s1[r*N_AXES+c] <= $signed(mat[r*4+c]) * crd[c];
				end
				bias_s1[r] <= $signed(mat[r*4+3]);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < N_ROWS; r++) begin
			acc[r] = (prod_s1[r*N_AXES] >>> FIX_SHIFT)
				+ (prod_s1[r*N_AXES+1] >>> FIX_SHIFT)
				+ (prod_s1[r*N_AXES+2] >>> FIX_SHIFT)
				+ ($signed({{(PROD_W-ENTRY_W){bias_s1[r][ENTRY_W-1]}}, bias_s1[r]})
					<<< FIX_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < N_ROWS; r++) begin
				dot_s2[r] <= acc[r][DOT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wtsp_div.sv =====
`default_nettype none

module wtsp_div import wtsp_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [NUMIN_W-1:0] num,
	input  logic signed [DOT_W-1:0]   den,
	input  logic [SCALE_W-1:0]        scale,
	output logic [CW-1:0]             value,
	output logic                      sat
);

	localparam int MP_W  = NUMIN_W + SCALE_W;
	localparam int NUM_W = MP_W + SCALE_SHIFT;
	localparam int HI_W  = NUM_W - CW;
	localparam int CMP_W = (HI_W > DOT_W) ? HI_W : DOT_W;

	logic               neg_sa;
	logic [NUMIN_W-1:0] un_sa;
	logic [DOT_W-1:0]   ud_sa;

	logic [MP_W-1:0]    mp;
	logic [NUM_W-1:0]   n_sb;
	logic [DOT_W-1:0]   ud_sb;
	logic               neg_sb;
	logic [HI_W-1:0]    hi;

	logic [DOT_W-1:0]   rem_si [CW+1];
	logic [CW-1:0]      lo_si  [CW+1];
	logic [CW-1:0]      q_si   [CW+1];
	logic [DOT_W-1:0]   ud_si  [CW+1];
	logic               neg_si [CW+1];
	logic               big_si [CW+1];

	logic [CW-1:0]      q;
	logic [CW-1:0]      val_c;
	logic               sat_c;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sa <= num[NUMIN_W-1] ^ den[DOT_W-1];
			un_sa  <= num[NUMIN_W-1] ? (~num + 1'b1) : num;
			ud_sa  <= den[DOT_W-1] ? (~den + 1'b1) : den;
		end
	end

	assign mp = un_sa * scale;

	always_ff @(posedge clk) begin
		if (en) begin
			n_sb   <= {mp, {SCALE_SHIFT{1'b0}}};
			ud_sb  <= ud_sa;
			neg_sb <= neg_sa;
		end
	end

	// The high part of the dividend decides whether the quotient fits at all.
	assign hi = n_sb[NUM_W-1:CW];

	always_ff @(posedge clk) begin
		if (en) begin
			big_si[0] <= CMP_W'(hi) >= CMP_W'(ud_sb);
			rem_si[0] <= DOT_W'(hi);
			lo_si[0]  <= n_sb[CW-1:0];
			q_si[0]   <= '0;
			ud_si[0]  <= ud_sb;
			neg_si[0] <= neg_sb;
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_iter
		logic [DOT_W:0] t;
		logic [DOT_W:0] diff;
		logic           ge;

		assign t    = {rem_si[k], lo_si[k][CW-1]};
		assign diff = t - {1'b0, ud_si[k]};
		assign ge   = t >= {1'b0, ud_si[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_si[k+1] <= ge ? diff[DOT_W-1:0] : t[DOT_W-1:0];
				lo_si[k+1]  <= lo_si[k] << 1;
				q_si[k+1]   <= {q_si[k][CW-2:0], ge};
				ud_si[k+1]  <= ud_si[k];
				neg_si[k+1] <= neg_si[k];
				big_si[k+1] <= big_si[k];
			end
		end
	end

	assign q = q_si[CW];

	always_comb begin
		if (!neg_si[CW]) begin
			sat_c = big_si[CW] | q[CW-1];
			val_c = sat_c ? {1'b0, {(CW-1){1'b1}}} : q;
		end else begin
			sat_c = big_si[CW] | (q[CW-1] & (|q[CW-2:0]));
			val_c = sat_c ? {1'b1, {(CW-1){1'b0}}} : (~q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= val_c;
			sat   <= sat_c;
		end
	end

endmodule

`default_nettype wire

// ===== dv/world_to_screen_projection_unit_tb.sv =====
`timescale 1ns / 1ps

module world_to_screen_projection_unit_tb;
	import wtsp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	typedef struct {
		logic        act;
		logic [3:0]  idx;
		logic [31:0] val;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} request_t;

	typedef struct {
		logic        vis;
		logic [31:0] sx;
		logic [31:0] sy;
		logic        ovf;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_WRITE;
	logic [3:0] entry_index = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [31:0] world_x = '0;
	logic signed [31:0] world_y = '0;
	logic signed [31:0] world_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic overflow;

	request_t pending[$];
	pixel_t expected_pixels[$];
	logic signed [31:0] view_mat[16];
	logic [13:0] width_r = WIDTH_RST;
	logic [13:0] height_r = HEIGHT_RST;
	logic [16:0] near_r = NEAR_RST;
	int errors = 0;
	int cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit quiet = 0;
	bit in_taken = 0;

	world_to_screen_projection_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .action(action),
		.entry_index(entry_index), .entry_value(entry_value), .world_x(world_x),
		.world_y(world_y), .world_z(world_z), .out_valid(out_valid),
		.out_ready(out_ready), .visible(visible), .screen_x(screen_x),
		.screen_y(screen_y), .overflow(overflow)
	);

	always #10 clk = ~clk;

	function automatic longint row_depth(int r, longint x, longint y, longint z);
		longint a, b, c, d;
		a = longint'(view_mat[r*4]);
		b = longint'(view_mat[r*4+1]);
		c = longint'(view_mat[r*4+2]);
		d = longint'(view_mat[r*4+3]);
		return ((a * x) >>> 8) + ((b * y) >>> 8) + ((c * z) >>> 8) + d * 256;
	endfunction

	function automatic logic [31:0] pixel_div(longint num, longint den, logic [13:0] scale,
			inout logic sat);
		logic [127:0] un, ud, q;
		logic neg;
		neg = (num < 0) != (den < 0);
		un = 128'(num < 0 ? -num : num);
		ud = 128'(den < 0 ? -den : den);
		q = ((un * 128'(scale)) << 15) / ud;
		if (!neg) begin
			if (q > 128'h7fff_ffff) begin
				sat = 1'b1;
				return 32'h7fff_ffff;
			end
			return q[31:0];
		end
		if (q > 128'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		q = -q;
		return q[31:0];
	endfunction

	function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		pixel_t p;
		longint x, y, z, d0, d1, d2, d3;
		logic sat;
		p = '{1'b0, 32'h0, 32'h0, 1'b0};
		sat = 1'b0;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		d2 = row_depth(2, x, y, z);
		if (d2 < longint'(near_r) * 65536)
			return p;
		d3 = row_depth(3, x, y, z);
		if (d3 == 0) begin
			p.ovf = 1'b1;
			return p;
		end
		d0 = row_depth(0, x, y, z);
		d1 = row_depth(1, x, y, z);
		p.vis = 1'b1;
		p.sx = pixel_div(d0 + d3, d3, width_r, sat);
		p.sy = pixel_div(d3 - d1, d3, height_r, sat);
		p.ovf = sat;
		return p;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return ($urandom_range(0, 2)) == 0 ? 32'h7fff_ffff :
				(($urandom_range(0, 1)) == 0 ? 32'h8000_0000 : 32'h0);
			2: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
			default: return 32'($signed($urandom_range(0, 32'h0064_0000)) - 32'sh0032_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return ($urandom_range(0, 1)) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
			2: return 32'h0;
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic request_t write_req(int idx, logic [31:0] val);
		return '{ACT_WRITE, 4'(idx), val, $urandom(), $urandom(), $urandom()};
	endfunction

	function automatic request_t point_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		return '{ACT_PROJECT, 4'($urandom()), $urandom(), x, y, z};
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_frames(int count);
		int i, k;
		for (k = 0; k < 16; k++)
			pending.push_back(write_req(k, (k == 15) ? ONE_Q24 : rand_entry()));
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				pending.push_back(write_req($urandom_range(0, 15), rand_entry()));
			else
				pending.push_back(point_req(rand_coord(), rand_coord(), rand_coord()));
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		pixel_t exp_p;
		in_taken = 0;
		if (arst_n && in_valid && in_ready) begin
			in_taken = 1;
			if (action == ACT_WRITE)
				view_mat[entry_index] = entry_value;
			else
				expected_pixels.push_back(project_point(world_x, world_y, world_z));
		end
		if (arst_n && cfg_write) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH: width_r = cfg_data[13:0];
				CFG_SCREEN_HEIGHT: height_r = cfg_data[13:0];
				CFG_NEAR_LIMIT: near_r = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with none expected: %b %h %h %b", $realtime,
					visible, screen_x, screen_y, overflow);
				errors++;
			end else begin
				exp_p = expected_pixels.pop_front();
				if (visible !== exp_p.vis) begin
					$display("%0t: visible expected %b actual %b", $realtime, exp_p.vis, visible);
					errors++;
				end
				if (screen_x !== exp_p.sx) begin
					$display("%0t: screen_x expected %h actual %h", $realtime, exp_p.sx, screen_x);
					errors++;
				end
				if (screen_y !== exp_p.sy) begin
					$display("%0t: screen_y expected %h actual %h", $realtime, exp_p.sy, screen_y);
					errors++;
				end
				if (overflow !== exp_p.ovf) begin
					$display("%0t: overflow expected %b actual %b", $realtime, exp_p.ovf, overflow);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
				in_gap = $urandom_range(1, 5);
			if (in_gap > 0 || pending.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap > 0)
					in_gap--;
			end else begin
				r = pending.pop_front();
				in_valid <= 1'b1;
				action <= r.act;
				entry_index <= r.idx;
				entry_value <= r.val;
				world_x <= r.x;
				world_y <= r.y;
				world_z <= r.z;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			out_gap = $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		for (int k = 0; k < 16; k++)
			view_mat[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// An empty matrix rejects every point, then an identity view exercises the mapping.
		pending.push_back(point_req(32'h0, 32'h0, 32'h0));
		pending.push_back(point_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		pending.push_back(write_req(0, ONE_Q24));
		pending.push_back(write_req(5, ONE_Q24));
		pending.push_back(write_req(10, ONE_Q24));
		pending.push_back(write_req(15, ONE_Q24));
		pending.push_back(point_req(32'h0000_8000, 32'hffff_8000, ONE_Q16));
		pending.push_back(point_req(32'h0, 32'h0, 32'h0));
		pending.push_back(point_req(32'h0, 32'h0, 32'h0000_0042));
		pending.push_back(point_req(32'h0, 32'h0, 32'h0000_0041));
		pending.push_back(point_req(32'h7fff_ffff, 32'h8000_0000, ONE_Q16));
		pending.push_back(point_req(32'h8000_0000, 32'h7fff_ffff, ONE_Q16));
		pending.push_back(write_req(15, 32'h0));
		pending.push_back(point_req(ONE_Q16, ONE_Q16, ONE_Q16));
		pending.push_back(write_req(15, 32'h8000_0000));
		pending.push_back(point_req(ONE_Q16, 32'h8000_0000, 32'h7fff_ffff));
		pending.push_back(write_req(15, 32'h7fff_ffff));
		pending.push_back(write_req(11, 32'h8000_0000));
		pending.push_back(point_req(32'h8000_0000, ONE_Q16, 32'h8000_0000));
		random_frames(200);
		drain();

		set_reg(CFG_SCREEN_WIDTH, 17'd8192);
		set_reg(CFG_SCREEN_HEIGHT, 17'd8192);
		set_reg(CFG_NEAR_LIMIT, 17'd0);
		pending.push_back(write_req(15, 32'h0));
		pending.push_back(write_req(14, 32'h0));
		pending.push_back(point_req(32'h0, 32'h0, 32'h0));
		random_frames(180);
		drain();

		set_reg(CFG_SCREEN_WIDTH, 17'd1);
		set_reg(CFG_SCREEN_HEIGHT, 17'd1);
		set_reg(CFG_NEAR_LIMIT, 17'd65536);
		random_frames(180);
		drain();

		set_reg(CFG_SCREEN_WIDTH, 17'h1_ffff);
		set_reg(CFG_SCREEN_HEIGHT, 17'd0);
		set_reg(CFG_NEAR_LIMIT, 17'h1_ffff);
		set_reg(CFG_UNUSED, 17'h1_5555);
		random_frames(150);
		drain();

		set_reg(CFG_SCREEN_WIDTH, 17'($urandom_range(1, 8192)));
		set_reg(CFG_SCREEN_HEIGHT, 17'($urandom_range(1, 8192)));
		set_reg(CFG_NEAR_LIMIT, 17'($urandom_range(0, 300)));
		quiet = 1;
		random_frames(150);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wtsp_pkg.sv
rtl/wtsp_dot.sv
rtl/wtsp_div.sv
rtl/world_to_screen_projection_unit.sv
dv/world_to_screen_projection_unit_tb.sv
